/* hdl/quad_overlap_sat_test_core_macros.svh */
// Assertion macros shared by the checker files.
`ifndef QUAD_OVERLAP_SAT_TEST_CORE_MACROS_SVH
`define QUAD_OVERLAP_SAT_TEST_CORE_MACROS_SVH

// ante implies cons on the same edge
`define QOST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qost assertion failed");

// ante implies cons at the later edge given by dly
`define QOST_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("qost assertion failed");

`endif

/* hdl/qost_pkg.sv */
// Shared constants and helpers for the quad overlap test core.
package qost_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int HALF_BITS          = 16;
    localparam int WORD_BITS          = 32;
    localparam int CORNERS_PER_QUAD   = 4;
    localparam int NUM_PTS            = 8;
    localparam int NUM_AXES           = 8;
    // accept edge to the edge that takes the result
    localparam int PIPE_LATENCY       = 6;

    // coordinate width actually used: capped at one packed half
    function automatic int coord_width(input int coord_bits);
        return (coord_bits < HALF_BITS) ? coord_bits : HALF_BITS;
    endfunction

endpackage

/* hdl/qost_edge.sv */
// Corner unpack and edge-normal axis generation, one register stage.
module qost_edge
    import qost_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    localparam int CW = coord_width(COORD_BITS),
    localparam int EW = CW + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [WORD_BITS-1:0] corner [NUM_PTS],
    output logic                 pt_valid,
    output logic signed [CW-1:0] px [NUM_PTS],
    output logic signed [CW-1:0] py [NUM_PTS],
    output logic signed [EW-1:0] ax [NUM_AXES],
    output logic signed [EW-1:0] ay [NUM_AXES]
);

    logic signed [CW-1:0] px_next [NUM_PTS];
    logic signed [CW-1:0] py_next [NUM_PTS];
    logic signed [EW-1:0] ax_next [NUM_AXES];
    logic signed [EW-1:0] ay_next [NUM_AXES];
    logic signed [CW-1:0] px_reg  [NUM_PTS];
    logic signed [CW-1:0] py_reg  [NUM_PTS];
    logic signed [EW-1:0] ax_reg  [NUM_AXES];
    logic signed [EW-1:0] ay_reg  [NUM_AXES];
    logic                 valid_reg;

    // low CW bits of each half, sign taken from bit CW-1
    always_comb
    begin
        for (int c = 0; c < NUM_PTS; c++)
        begin
            px_next[c] = corner[c][CW-1:0];
            py_next[c] = corner[c][HALF_BITS+CW-1:HALF_BITS];
        end
    end

    // axis k: normal (-ey, ex) of edge k%4 of quad k/4
    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_axis
        localparam int BASE = (k / CORNERS_PER_QUAD) * CORNERS_PER_QUAD;
        localparam int IDX0 = BASE + (k % CORNERS_PER_QUAD);
        localparam int IDX1 = BASE + ((k + 1) % CORNERS_PER_QUAD);
        logic signed [EW-1:0] ex;
        logic signed [EW-1:0] ey;
        assign ex = EW'(px_next[IDX1]) - EW'(px_next[IDX0]);
        assign ey = EW'(py_next[IDX1]) - EW'(py_next[IDX0]);
        assign ax_next[k] = -ey;
        assign ay_next[k] = ex;
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    assign pt_valid = valid_reg;
    assign px       = px_reg;
    assign py       = py_reg;
    assign ax       = ax_reg;
    assign ay       = ay_reg;

endmodule

/* hdl/qost_project.sv */
// Projection of all corners on all axes: multiply, add, min/max stages.
module qost_project
    import qost_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    localparam int CW = coord_width(COORD_BITS),
    localparam int EW = CW + 1,
    localparam int PW = CW + EW,
    localparam int DW = PW + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pt_valid,
    input  logic signed [CW-1:0] px [NUM_PTS],
    input  logic signed [CW-1:0] py [NUM_PTS],
    input  logic signed [EW-1:0] ax [NUM_AXES],
    input  logic signed [EW-1:0] ay [NUM_AXES],
    output logic                 iv_valid,
    output logic signed [DW-1:0] lo_a [NUM_AXES],
    output logic signed [DW-1:0] hi_a [NUM_AXES],
    output logic signed [DW-1:0] lo_b [NUM_AXES],
    output logic signed [DW-1:0] hi_b [NUM_AXES]
);

    logic signed [PW-1:0] prodx_next [NUM_AXES][NUM_PTS];
    logic signed [PW-1:0] prody_next [NUM_AXES][NUM_PTS];
    logic signed [PW-1:0] prodx_reg  [NUM_AXES][NUM_PTS];
    logic signed [PW-1:0] prody_reg  [NUM_AXES][NUM_PTS];
    logic signed [DW-1:0] dot_next   [NUM_AXES][NUM_PTS];
    logic signed [DW-1:0] dot_reg    [NUM_AXES][NUM_PTS];
    logic signed [DW-1:0] lo_a_next  [NUM_AXES];
    logic signed [DW-1:0] hi_a_next  [NUM_AXES];
    logic signed [DW-1:0] lo_b_next  [NUM_AXES];
    logic signed [DW-1:0] hi_b_next  [NUM_AXES];
    logic signed [DW-1:0] lo_a_reg   [NUM_AXES];
    logic signed [DW-1:0] hi_a_reg   [NUM_AXES];
    logic signed [DW-1:0] lo_b_reg   [NUM_AXES];
    logic signed [DW-1:0] hi_b_reg   [NUM_AXES];
    logic [2:0]           valid_reg;

    // one multiplier per lane, registered
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            for (int c = 0; c < NUM_PTS; c++)
            begin
                prodx_next[k][c] = PW'(px[c]) * PW'(ax[k]);
                prody_next[k][c] = PW'(py[c]) * PW'(ay[k]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            for (int c = 0; c < NUM_PTS; c++)
            begin
                dot_next[k][c] = DW'(prodx_reg[k][c]) + DW'(prody_reg[k][c]);
            end
        end
    end

    // interval of each quad on each axis
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            lo_a_next[k] = dot_reg[k][0];
            hi_a_next[k] = dot_reg[k][0];
            lo_b_next[k] = dot_reg[k][CORNERS_PER_QUAD];
            hi_b_next[k] = dot_reg[k][CORNERS_PER_QUAD];
            for (int c = 1; c < CORNERS_PER_QUAD; c++)
            begin
                if (dot_reg[k][c] < lo_a_next[k])
                begin
                    lo_a_next[k] = dot_reg[k][c];
                end
                if (dot_reg[k][c] > hi_a_next[k])
                begin
                    hi_a_next[k] = dot_reg[k][c];
                end
                if (dot_reg[k][c+CORNERS_PER_QUAD] < lo_b_next[k])
                begin
                    lo_b_next[k] = dot_reg[k][c+CORNERS_PER_QUAD];
                end
                if (dot_reg[k][c+CORNERS_PER_QUAD] > hi_b_next[k])
                begin
                    hi_b_next[k] = dot_reg[k][c+CORNERS_PER_QUAD];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prodx_reg <= prodx_next;
        prody_reg <= prody_next;
        dot_reg   <= dot_next;
        lo_a_reg  <= lo_a_next;
        hi_a_reg  <= hi_a_next;
        lo_b_reg  <= lo_b_next;
        hi_b_reg  <= hi_b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], pt_valid};
        end
    end

    assign iv_valid = valid_reg[2];
    assign lo_a     = lo_a_reg;
    assign hi_a     = hi_a_reg;
    assign lo_b     = lo_b_reg;
    assign hi_b     = hi_b_reg;

endmodule

/* hdl/qost_decide.sv */
// Interval gap check over all axes and result register.
module qost_decide
    import qost_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    localparam int CW = coord_width(COORD_BITS),
    localparam int DW = 2 * CW + 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 iv_valid,
    input  logic signed [DW-1:0] lo_a [NUM_AXES],
    input  logic signed [DW-1:0] hi_a [NUM_AXES],
    input  logic signed [DW-1:0] lo_b [NUM_AXES],
    input  logic signed [DW-1:0] hi_b [NUM_AXES],
    output logic                 done,
    output logic                 overlap
);

    logic apart;
    logic overlap_reg;
    logic done_reg;

    // strict gap on any axis separates; touching does not
    always_comb
    begin
        apart = 1'b0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if ((hi_a[k] < lo_b[k]) || (hi_b[k] < lo_a[k]))
            begin
                apart = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (iv_valid)
        begin
            overlap_reg <= !apart;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= iv_valid;
        end
    end

    assign done    = done_reg;
    assign overlap = overlap_reg;

endmodule

/* hdl/quad_overlap_sat_test_core.sv */
// Top level of the quad overlap test core (separating axis test).
//
// Usage:
//   A request is the eight corner words of two quads (y[31:16], x[15:0],
//   signed Q12.4). It is taken at a rising edge where start is high and
//   busy is low. busy is held low: a new request can be issued every
//   cycle, with no gaps needed.
//   Each request yields exactly one result: overlap on the output port,
//   marked by done for exactly one cycle. overlap is 1 when no edge
//   normal of either quad separates them; touching counts as overlap.
//   A request passes the input register and then the register stages
//   (edge axes, products, dot sums, min/max intervals, gap compare).
//   Throughput: one request per cycle, since each of these stages works
//   on a new request every cycle.
//   Results come in request order. The receiver cannot stall; done is a
//   strobe and must be sampled when it is high.
//   Reset (rst_n low, async) clears all valid flags; requests in flight
//   are dropped and no done appears until a new request enters.
//   COORD_BITS narrows the coordinates; above 16 it is capped at 16.
module quad_overlap_sat_test_core
    import qost_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] quad_a_corner0,
    input  logic [WORD_BITS-1:0] quad_a_corner1,
    input  logic [WORD_BITS-1:0] quad_a_corner2,
    input  logic [WORD_BITS-1:0] quad_a_corner3,
    input  logic [WORD_BITS-1:0] quad_b_corner0,
    input  logic [WORD_BITS-1:0] quad_b_corner1,
    input  logic [WORD_BITS-1:0] quad_b_corner2,
    input  logic [WORD_BITS-1:0] quad_b_corner3,
    output logic                 done,
    output logic                 overlap
);

    localparam int CW = coord_width(COORD_BITS);
    localparam int EW = CW + 1;
    localparam int DW = 2 * CW + 2;

    logic                 accept;
    logic [WORD_BITS-1:0] corner_next [NUM_PTS];
    logic [WORD_BITS-1:0] corner_reg  [NUM_PTS];
    logic                 in_valid_reg;

    logic                 pt_valid;
    logic signed [CW-1:0] px [NUM_PTS];
    logic signed [CW-1:0] py [NUM_PTS];
    logic signed [EW-1:0] ax [NUM_AXES];
    logic signed [EW-1:0] ay [NUM_AXES];

    logic                 iv_valid;
    logic signed [DW-1:0] lo_a [NUM_AXES];
    logic signed [DW-1:0] hi_a [NUM_AXES];
    logic signed [DW-1:0] lo_b [NUM_AXES];
    logic signed [DW-1:0] hi_b [NUM_AXES];

    // fully pipelined: never busy
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // corners 0..3 belong to quad A, 4..7 to quad B
    assign corner_next[0] = quad_a_corner0;
    assign corner_next[1] = quad_a_corner1;
    assign corner_next[2] = quad_a_corner2;
    assign corner_next[3] = quad_a_corner3;
    assign corner_next[4] = quad_b_corner0;
    assign corner_next[5] = quad_b_corner1;
    assign corner_next[6] = quad_b_corner2;
    assign corner_next[7] = quad_b_corner3;

    // input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    // stage: unpack and edge normals
    qost_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .corner   (corner_reg),
        .pt_valid (pt_valid),
        .px       (px),
        .py       (py),
        .ax       (ax),
        .ay       (ay)
    );

    // stages: products, dot sums, per-quad intervals
    qost_project #(
        .COORD_BITS (COORD_BITS)
    ) u_project (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt_valid (pt_valid),
        .px       (px),
        .py       (py),
        .ax       (ax),
        .ay       (ay),
        .iv_valid (iv_valid),
        .lo_a     (lo_a),
        .hi_a     (hi_a),
        .lo_b     (lo_b),
        .hi_b     (hi_b)
    );

    // stage: gap compare and result strobe
    qost_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .clk      (clk),
        .rst_n    (rst_n),
        .iv_valid (iv_valid),
        .lo_a     (lo_a),
        .hi_a     (hi_a),
        .lo_b     (lo_b),
        .hi_b     (hi_b),
        .done     (done),
        .overlap  (overlap)
    );

endmodule

/* hdl/qost_checker.sv */
// Port-level assertion checker for the quad overlap test core, with bind.
`include "quad_overlap_sat_test_core_macros.svh"

module qost_checker
    import qost_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [WORD_BITS-1:0] quad_a_corner0,
    input logic [WORD_BITS-1:0] quad_a_corner1,
    input logic [WORD_BITS-1:0] quad_a_corner2,
    input logic [WORD_BITS-1:0] quad_a_corner3,
    input logic [WORD_BITS-1:0] quad_b_corner0,
    input logic [WORD_BITS-1:0] quad_b_corner1,
    input logic [WORD_BITS-1:0] quad_b_corner2,
    input logic [WORD_BITS-1:0] quad_b_corner3,
    input logic                 done,
    input logic                 overlap
);

    logic req;
    logic same_quads;

    assign req        = start && !busy;
    assign same_quads = (quad_a_corner0 == quad_b_corner0) &&
                        (quad_a_corner1 == quad_b_corner1) &&
                        (quad_a_corner2 == quad_b_corner2) &&
                        (quad_a_corner3 == quad_b_corner3);

    // every request gives one strobe after the pipeline latency
    `QOST_ASSERT_DELAY(a_req_done, clk, rst_n, req, PIPE_LATENCY, done)
    // and no strobe appears without a request
    `QOST_ASSERT_DELAY(a_no_req_no_done, clk, rst_n, !req, PIPE_LATENCY, !done)
    // a quad always overlaps itself
    `QOST_ASSERT_DELAY(a_self_overlap, clk, rst_n, req && same_quads, PIPE_LATENCY, overlap)
    // pipeline accepts every cycle
    `QOST_ASSERT_IMPLY(a_start_taken, clk, rst_n, start, !busy)

endmodule

bind quad_overlap_sat_test_core qost_checker u_qost_checker (.*);

/* tb/sv/quad_overlap_checker.sv */
// Checker for the quad overlap core: predicts each request's overlap flag and compares results.
`timescale 1ns / 100ps
module quad_overlap_checker
    import qost_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [WORD_BITS-1:0] quad_a_corner0,
    input  logic [WORD_BITS-1:0] quad_a_corner1,
    input  logic [WORD_BITS-1:0] quad_a_corner2,
    input  logic [WORD_BITS-1:0] quad_a_corner3,
    input  logic [WORD_BITS-1:0] quad_b_corner0,
    input  logic [WORD_BITS-1:0] quad_b_corner1,
    input  logic [WORD_BITS-1:0] quad_b_corner2,
    input  logic [WORD_BITS-1:0] quad_b_corner3,
    input  logic                 done,
    input  logic                 overlap,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int CRD_W        = (COORD_BITS < HALF_BITS) ? COORD_BITS : HALF_BITS;
    localparam int REPORT_LIMIT = 10;

    typedef logic [WORD_BITS-1:0] corner_set_t [CORNERS_PER_QUAD];
    typedef struct {
        longint x;
        longint y;
    } point_t;
    typedef point_t quad_pts_t [CORNERS_PER_QUAD];
    typedef struct {
        int unsigned tag;
        bit          flag;
    } overlap_due_t;

    overlap_due_t overlap_due [$];
    overlap_due_t oldest;
    overlap_due_t fresh;
    int unsigned  req_count;

    // low CRD_W bits of a half, sign-extended
    function automatic longint coord(input logic [HALF_BITS-1:0] h);
        longint v;
        longint sgn;
        sgn = longint'(1) << (CRD_W - 1);
        v   = longint'(h) & ((longint'(1) << CRD_W) - 1);
        return (v ^ sgn) - sgn;
    endfunction

    function automatic quad_pts_t to_points(input corner_set_t w);
        quad_pts_t q;
        for (int k = 0; k < CORNERS_PER_QUAD; k++)
        begin
            q[k].x = coord(w[k][HALF_BITS-1:0]);
            q[k].y = coord(w[k][WORD_BITS-1:HALF_BITS]);
        end
        return q;
    endfunction

    // interval covered by a quad on axis (ax, ay), unnormalized
    function automatic void span(input quad_pts_t q, input longint ax, input longint ay,
                                 output longint lo, output longint hi);
        longint d;
        lo = q[0].x * ax + q[0].y * ay;
        hi = lo;
        for (int k = 1; k < CORNERS_PER_QUAD; k++)
        begin
            d = q[k].x * ax + q[k].y * ay;
            if (d < lo) lo = d;
            if (d > hi) hi = d;
        end
    endfunction

    // some edge normal of e leaves a strict gap to o; null edges never separate
    function automatic bit edge_separates(input quad_pts_t e, input quad_pts_t o);
        longint ax, ay, lo_e, hi_e, lo_o, hi_o;
        for (int i = 0; i < CORNERS_PER_QUAD; i++)
        begin
            ax = -(e[(i + 1) % CORNERS_PER_QUAD].y - e[i].y);
            ay =   e[(i + 1) % CORNERS_PER_QUAD].x - e[i].x;
            span(e, ax, ay, lo_e, hi_e);
            span(o, ax, ay, lo_o, hi_o);
            if (hi_e < lo_o || hi_o < lo_e) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit quads_overlap(input corner_set_t wa, input corner_set_t wb);
        quad_pts_t a, b;
        a = to_points(wa);
        b = to_points(wb);
        return !(edge_separates(a, b) || edge_separates(b, a));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_due.delete();
            req_count   = 0;
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (overlap_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result overlap=%0b with no request pending",
                                 $realtime, overlap);
                end
                else
                begin
                    oldest = overlap_due.pop_front();
                    if (overlap !== oldest.flag)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: request %0d overlap expected %0b, got %b",
                                     $realtime, oldest.tag, oldest.flag, overlap);
                    end
                end
            end
            if (start && !busy)
            begin
                fresh.tag  = req_count;
                fresh.flag = quads_overlap(
                    '{quad_a_corner0, quad_a_corner1, quad_a_corner2, quad_a_corner3},
                    '{quad_b_corner0, quad_b_corner1, quad_b_corner2, quad_b_corner3});
                overlap_due = {overlap_due, fresh};
                req_count++;
            end
            outstanding = overlap_due.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Top of the quad overlap testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
    import qost_pkg::*;

    localparam int RANDOM_REQUESTS = 930;
    // cycles with neither a request taken nor a result seen before giving up
    localparam int IDLE_LIMIT      = 1000;

    typedef logic [WORD_BITS-1:0] corner_set_t [CORNERS_PER_QUAD];

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [WORD_BITS-1:0] quad_a_corner0;
    logic [WORD_BITS-1:0] quad_a_corner1;
    logic [WORD_BITS-1:0] quad_a_corner2;
    logic [WORD_BITS-1:0] quad_a_corner3;
    logic [WORD_BITS-1:0] quad_b_corner0;
    logic [WORD_BITS-1:0] quad_b_corner1;
    logic [WORD_BITS-1:0] quad_b_corner2;
    logic [WORD_BITS-1:0] quad_b_corner3;
    logic                 done;
    logic                 overlap;

    int          mismatches;
    int          outstanding;
    int          idle_cycles;
    int          burst_left;
    corner_set_t qa, qb;
    corner_set_t junk_a, junk_b;

    quad_overlap_sat_test_core DUT (.*);

    quad_overlap_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hang anywhere (lost result, stuck busy) ends the run here.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // corner word: y in the upper half, x in the lower, raw Q12.4 counts
    function automatic logic [WORD_BITS-1:0] pack_xy(input int x, input int y);
        return {16'(y), 16'(x)};
    endfunction

    // axis-aligned box, corners counter-clockwise; a point when x0==x1, y0==y1
    function automatic corner_set_t box(input int x0, input int y0, input int x1, input int y1);
        return '{pack_xy(x0, y0), pack_xy(x1, y0), pack_xy(x1, y1), pack_xy(x0, y1)};
    endfunction

    // parallelogram around (cx, cy) spanned by half-vectors u and v
    function automatic corner_set_t parallelogram(input int cx, input int cy,
                                                  input int ux, input int uy,
                                                  input int vx, input int vy);
        return '{pack_xy(cx - ux - vx, cy - uy - vy), pack_xy(cx + ux - vx, cy + uy - vy),
                 pack_xy(cx + ux + vx, cy + uy + vy), pack_xy(cx - ux + vx, cy - uy + vy)};
    endfunction

    // uniform in [-r, r]
    function automatic int sym(input int r);
        return int'($urandom_range(2 * r, 0)) - r;
    endfunction

    // mostly short bursts, now and then a long one with no idling at all
    function automatic int next_burst_len();
        return ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 300))
                                           : int'($urandom_range(1, 24));
    endfunction

    task automatic drive_fields(input corner_set_t a, input corner_set_t b);
        quad_a_corner0 <= a[0];
        quad_a_corner1 <= a[1];
        quad_a_corner2 <= a[2];
        quad_a_corner3 <= a[3];
        quad_b_corner0 <= b[0];
        quad_b_corner1 <= b[1];
        quad_b_corner2 <= b[2];
        quad_b_corner3 <= b[3];
    endtask

    // Random pair. Most are two parallelograms of similar size placed close
    // enough that overlap and separation both occur often; some are raw noise
    // words (every bit of every field toggles), some are shapes with a stray
    // or repeated corner.
    task automatic make_random_pair(output corner_set_t a, output corner_set_t b);
        int kind, r, cx, cy, slot;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            foreach (a[k])
            begin
                a[k] = $urandom;
                b[k] = $urandom;
            end
        end
        else
        begin
            r  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(300, 3000))
                                             : int'($urandom_range(1, 300));
            cx = sym(16000);
            cy = sym(16000);
            a  = parallelogram(cx, cy, sym(r), sym(r), sym(r), sym(r));
            b  = parallelogram(cx + sym(3 * r), cy + sym(3 * r), sym(r), sym(r), sym(r), sym(r));
            if (kind >= 85)
            begin
                slot = $urandom_range(0, 3);
                case ($urandom_range(0, 3))
                    0:       a[slot] = $urandom;
                    1:       b[slot] = $urandom;
                    2:       a[slot] = a[(slot + 1) % CORNERS_PER_QUAD];
                    default: b[slot] = b[(slot + 1) % CORNERS_PER_QUAD];
                endcase
            end
        end
    endtask

    // Present one request and hold it until taken. busy is read before the
    // edge's updates land, so the loop exits on the accepting edge. When the
    // burst runs out, start drops and junk sits on the fields for the gap.
    task automatic send_request(input corner_set_t a, input corner_set_t b);
        drive_fields(a, b);
        start <= 1'b1;
        do @(posedge clk); while (busy);
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            make_random_pair(junk_a, junk_b);
            drive_fields(junk_a, junk_b);
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = next_burst_len();
        end
    endtask

    // Hold off until every result in flight has come back.
    // The extra edge lets the checker log the last accepted request first.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        burst_left = next_burst_len();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        drive_fields('{default: '0}, '{default: '0});
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests, back to back in one burst.
        burst_left = 64;
        // all zero: every axis is null, nothing separates
        send_request(box(0, 0, 0, 0), box(0, 0, 0, 0));
        send_request(box(0, 0, 16, 16), box(0, 0, 16, 16));
        send_request(box(0, 0, 16, 16), box(32, 0, 48, 16));
        // shared edge: touching counts as overlap
        send_request(box(0, 0, 16, 16), box(16, 0, 32, 16));
        // one LSB apart in x, then in y
        send_request(box(0, 0, 16, 16), box(17, 0, 33, 16));
        send_request(box(0, 0, 16, 16), box(4, 17, 12, 40));
        // diamond vs box: bounding boxes overlap, diagonal edge separates or touches
        send_request('{pack_xy(100, 0), pack_xy(0, 100), pack_xy(-100, 0), pack_xy(0, -100)},
                     box(51, 51, 100, 100));
        send_request('{pack_xy(100, 0), pack_xy(0, 100), pack_xy(-100, 0), pack_xy(0, -100)},
                     box(50, 50, 100, 100));
        // full coordinate range, and far opposite corners
        send_request(box(-32768, -32768, 32767, 32767), box(-5, -5, 5, 5));
        send_request(box(-32768, -32768, -32000, -32000), box(32000, 32000, 32767, 32767));
        // zero-length edge (repeated corner), apart then overlapping
        send_request('{pack_xy(0, 0), pack_xy(0, 0), pack_xy(64, 0), pack_xy(0, 64)},
                     box(40, 40, 80, 80));
        send_request('{pack_xy(0, 0), pack_xy(0, 0), pack_xy(64, 0), pack_xy(0, 64)},
                     box(20, 20, 80, 80));
        // collapsed quad: point inside, point outside, two distinct points
        send_request(box(8, 8, 8, 8), box(0, 0, 16, 16));
        send_request(box(20, 8, 20, 8), box(0, 0, 16, 16));
        send_request(box(-100, -100, -100, -100), box(300, 200, 300, 200));
        // clockwise winding
        send_request('{pack_xy(0, 0), pack_xy(0, 16), pack_xy(16, 16), pack_xy(16, 0)},
                     box(-40, 0, -20, 16));
        // bow-tie (non-convex) and a collinear sliver
        send_request('{pack_xy(0, 0), pack_xy(32, 32), pack_xy(32, 0), pack_xy(0, 32)},
                     box(12, 12, 20, 20));
        send_request('{pack_xy(-50, 0), pack_xy(0, 0), pack_xy(50, 0), pack_xy(0, 0)},
                     box(-10, -10, 10, 10));
        // all ones, and most-positive vs most-negative single points
        send_request('{default: '1}, '{default: '1});
        send_request('{default: 32'h7FFF_7FFF}, '{default: 32'h8000_8000});
        // widest edges the format allows
        send_request('{pack_xy(-32768, -32768), pack_xy(32767, -32768),
                       pack_xy(32767, -32768), pack_xy(-32768, 32767)},
                     box(32000, 32000, 32767, 32767));
        send_request('{pack_xy(-32768, -32768), pack_xy(32767, -32768),
                       pack_xy(32767, 32767), pack_xy(-32768, 32767)},
                     '{pack_xy(32767, 32767), pack_xy(-32768, 32767),
                       pack_xy(-32768, -32768), pack_xy(32767, -32768)});
        drain();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            make_random_pair(qa, qb);
            send_request(qa, qb);
            if (n == RANDOM_REQUESTS / 2)
                drain();
        end

        // Let the pipeline empty, then wait on for any stray result.
        drain();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* quad_overlap_sat_test_core.f */
+incdir+hdl
hdl/qost_pkg.sv
hdl/qost_edge.sv
hdl/qost_project.sv
hdl/qost_decide.sv
hdl/quad_overlap_sat_test_core.sv
hdl/qost_checker.sv
tb/sv/quad_overlap_checker.sv
tb/sv/testbench.sv
